### design/integer_to_ascii_dec_hex_defines.svh
// Assertion macros for the integer to ASCII converter checker.
// No dependencies; included by the checker file.
`ifndef INTEGER_TO_ASCII_DEC_HEX_DEFINES_SVH
`define INTEGER_TO_ASCII_DEC_HEX_DEFINES_SVH

// Property checked outside reset.
`define ITI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ITI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/iti_pkg.sv
// Shared constants, types and the digit-to-character function.
// No dependencies.
`default_nettype none

package iti_pkg;

	localparam int IN_WIDTH    = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int DEC_BITS    = 32;
	localparam int HEX_CELLS   = (VALUE_WIDTH + 3) / 4;
	localparam int NCELL       = (HEX_CELLS > 10) ? HEX_CELLS : 10;
	localparam int VEC_W       = NCELL * 4;
	localparam int REM_W       = $clog2(NCELL + 1);
	localparam int CNT_W       = $clog2(DEC_BITS);

	typedef enum logic [1:0] {
		MODE_DEC    = 2'd0,
		MODE_HEX_LO = 2'd1,
		MODE_HEX_UP = 2'd2,
		MODE_PTR    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_LOAD   = 2'd1,
		CELL_DABBLE = 2'd2,
		CELL_SHIFT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     ser_bit;
	} cell_ctrl_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_A_LO  = 8'h61;
	localparam logic [7:0] CHAR_A_UP  = 8'h41;

	// One digit (0..15) to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CHAR_A_UP : CHAR_A_LO;
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + {4'd0, d};
		end else begin
			digit_char = base + {4'd0, d - 4'd10};
		end
	endfunction

endpackage

`default_nettype wire

### design/iti_cell.sv
// One digit cell: holds a 4-bit digit, loads a digit, does a double-dabble step or a digit shift.
// Depends on iti_pkg.
`default_nettype none

module iti_cell (
	input  wire              clk,
	input  iti_pkg::cell_op_t op,
	input  wire              bit_in,
	input  wire  [3:0]       dig_in,
	input  wire  [3:0]       load_dig,
	output logic [3:0]       digit,
	output logic             bit_out
);
	import iti_pkg::*;

	logic [3:0] dig_q;
	logic [3:0] adj;

	// add 3 when the digit is 5 or more, before the shift
	always_comb begin
		adj     = (dig_q >= 4'd5) ? dig_q + 4'd3 : dig_q;
		bit_out = adj[3];
		digit   = dig_q;
	end

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:   dig_q <= dig_q;
			CELL_LOAD:   dig_q <= load_dig;
			CELL_DABBLE: dig_q <= {adj[2:0], bit_in};
			CELL_SHIFT:  dig_q <= dig_in;
			default:     dig_q <= dig_q;
		endcase
	end

endmodule

`default_nettype wire

### design/iti_chain.sv
// Row of digit cells; cell 0 takes the serial bit, the top cell feeds the output.
// Depends on iti_pkg and iti_cell.
`default_nettype none

module iti_chain (
	input  wire                     clk,
	input  iti_pkg::cell_ctrl_t     ctrl,
	input  wire  [iti_pkg::VEC_W-1:0] load_vec,
	output logic [3:0]              top_dig
);
	import iti_pkg::*;

	logic [3:0] dig   [NCELL];
	logic       carry [NCELL-1];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic       b_in;
		logic [3:0] d_in;
		if (i == 0) begin : g_first
			assign b_in = ctrl.ser_bit;
			assign d_in = 4'd0;
		end else begin : g_rest
			assign b_in = carry[i-1];
			assign d_in = dig[i-1];
		end
		if (i < NCELL - 1) begin : g_mid
			iti_cell u_cell (
				.clk     (clk),
				.op      (ctrl.op),
				.bit_in  (b_in),
				.dig_in  (d_in),
				.load_dig(load_vec[4*i +: 4]),
				.digit   (dig[i]),
				.bit_out (carry[i])
			);
		end else begin : g_top
			iti_cell u_cell (
				.clk     (clk),
				.op      (ctrl.op),
				.bit_in  (b_in),
				.dig_in  (d_in),
				.load_dig(load_vec[4*i +: 4]),
				.digit   (dig[i]),
				.bit_out ()
			);
		end
	end

	assign top_dig = dig[NCELL-1];

endmodule

`default_nettype wire

### design/integer_to_ascii_dec_hex.sv
// Integer to ASCII text converter, decimal or hex, one character per word.
// Depends on iti_pkg, iti_chain (iti_cell).
//
//  channel | ports                    | handshake
//  --------+--------------------------+---------------------------------
//  input   | value, mode              | taken when start && !busy
//  output  | char_out, last           | one cycle per word, on strobe
//
// Decimal: 1 load + 32 double-dabble steps through the cell row, then up to
// 15 leading zeros dropped (one shift each), 1 turn step, then one character
// per cycle; skips and characters always add to 16.
// Hex: 1 load, up to 15 skips, 1 turn, then one character per cycle; pointer
// mode first gives the two prefix characters 0x.
// Reset (arst_n low) returns to idle and drops strobe; the row needs no clear.
// The receiver cannot stall: each word stands on the outputs for one cycle.
`default_nettype none

module integer_to_ascii_dec_hex (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [iti_pkg::IN_WIDTH-1:0] value,
	input  wire  [1:0]                   mode,
	output logic                         strobe,
	output logic [7:0]                   char_out,
	output logic                         last
);
	import iti_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CONV = 6'b000010,
		ST_PFX0 = 6'b000100,
		ST_PFXX = 6'b001000,
		ST_SKIP = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [DEC_BITS-1:0] work_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  remain_q;
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	cell_ctrl_t        ctrl;
	logic [VEC_W-1:0]  load_vec;
	logic [3:0]        top_dig;
	mode_t             mode_in;

	assign mode_in = mode_t'(mode);

	// parallel load word for the cell row
	always_comb begin
		unique case (mode_in)
			MODE_DEC:    load_vec = '0;
			MODE_PTR:    load_vec = VEC_W'(value[VALUE_WIDTH-1:0]);
			MODE_HEX_LO,
			MODE_HEX_UP: load_vec = VEC_W'(value[DEC_BITS-1:0]);
			default:     load_vec = '0;
		endcase
	end

	// cell row control
	always_comb begin
		ctrl.op      = CELL_HOLD;
		ctrl.ser_bit = work_q[DEC_BITS-1];
		unique case (state_q)
			ST_IDLE: if (start) ctrl.op = CELL_LOAD;
			ST_CONV: ctrl.op = CELL_DABBLE;
			ST_SKIP: if (top_dig == 4'd0 && remain_q > REM_W'(1)) ctrl.op = CELL_SHIFT;
			ST_EMIT: ctrl.op = CELL_SHIFT;
			default: ctrl.op = CELL_HOLD;
		endcase
	end

	iti_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.load_vec(load_vec),
		.top_dig (top_dig)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			remain_q <= '0;
			cnt_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						remain_q <= REM_W'(NCELL);
						cnt_q    <= '0;
						priority if (mode_in == MODE_DEC) state_q <= ST_CONV;
						else if (mode_in == MODE_PTR) state_q <= ST_PFX0;
						else state_q <= ST_SKIP;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DEC_BITS - 1)) state_q <= ST_SKIP;
				end
				ST_PFX0: begin
					strobe_q <= 1'b1;
					state_q  <= ST_PFXX;
				end
				ST_PFXX: begin
					strobe_q <= 1'b1;
					state_q  <= ST_SKIP;
				end
				ST_SKIP: begin
					if (top_dig == 4'd0 && remain_q > REM_W'(1)) begin
						remain_q <= remain_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					remain_q <= remain_q - REM_W'(1);
					if (remain_q == REM_W'(1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= mode_in;
			work_q <= value[DEC_BITS-1:0];
		end else if (state_q == ST_CONV) begin
			work_q <= {work_q[DEC_BITS-2:0], 1'b0};
		end
		unique case (state_q)
			ST_PFX0: begin
				char_q <= CHAR_ZERO;
				last_q <= 1'b0;
			end
			ST_PFXX: begin
				char_q <= CHAR_X;
				last_q <= 1'b0;
			end
			ST_EMIT: begin
				char_q <= digit_char(top_dig, mode_q == MODE_HEX_UP);
				last_q <= (remain_q == REM_W'(1));
			end
			default: begin
				char_q <= char_q;
				last_q <= last_q;
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign strobe   = strobe_q;
	assign char_out = char_q;
	assign last     = last_q;

endmodule

`default_nettype wire

### design/iti_checker.sv
// Port-level checks on the converter's command and word sequence, bound to the top.
// Depends on integer_to_ascii_dec_hex_defines.svh.
`default_nettype none

`include "integer_to_ascii_dec_hex_defines.svh"

module iti_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire strobe,
	input wire last
);

	// an accepted command makes the block busy
	`ITI_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "not busy after start")

	// idle means no word follows
	`ITI_ASSERT(a_idle_quiet, clk, arst_n, !busy |=> !strobe, "word while idle")

	// more words pending keeps the block busy
	`ITI_ASSERT(a_mid_busy, clk, arst_n, (strobe && !last) |-> busy, "idle mid text")

	// last word is never followed directly by another
	`ITI_ASSERT(a_last_gap, clk, arst_n, (strobe && last) |=> !strobe, "word after last")

	// reset holds the outputs quiet
	`ITI_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!strobe && !busy), "active in reset")

endmodule

bind integer_to_ascii_dec_hex iti_checker u_iti_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.strobe(strobe),
	.last  (last)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_dec_hex: directed and random values in all four modes.
// The predicted text of each accepted word is checked character by character.
// Depends on iti_pkg and the integer_to_ascii_dec_hex RTL.

module testbench;
	import iti_pkg::*;

	// One predicted output character
	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} text_char_t;

	// Holds the predicted text and checks each character that comes out
	class text_scoreboard;
		text_char_t text_q[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Digit to ASCII, hex letters in either case
		function logic [7:0] glyph(logic [3:0] d, logic upper);
			if (d < 4'd10) begin
				return 8'h30 + {4'd0, d};
			end
			return (upper ? 8'h41 : 8'h61) + {4'd0, d - 4'd10};
		endfunction

		function void push_char(logic [7:0] c, logic l);
			text_char_t t;
			t.ch  = c;
			t.lst = l;
			text_q.push_back(t);
		endfunction

		// Predict the text of one accepted word
		function void note_word(logic [63:0] v, mode_t m);
			logic [63:0] work;
			logic [3:0]  digits [20];
			int          n;
			logic        upper;
			n     = 0;
			upper = (m == MODE_HEX_UP);
			if (m == MODE_PTR) begin
				push_char(8'h30, 1'b0);
				push_char(8'h78, 1'b0);
				work = v & ((64'd1 << VALUE_WIDTH) - 64'd1);
			end else begin
				work = {32'd0, v[31:0]};
			end
			// least significant digit first; zero still gives one digit
			do begin
				if (m == MODE_DEC) begin
					digits[n] = 4'(work % 64'd10);
					work      = work / 64'd10;
				end else begin
					digits[n] = work[3:0];
					work      = work >> 4;
				end
				n++;
			end while (work != 64'd0);
			for (int i = n - 1; i >= 0; i--) begin
				push_char(glyph(digits[i], upper), i == 0);
			end
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		// Compare one output character with the oldest prediction
		task check_char(logic [7:0] c, logic l);
			text_char_t t;
			if (text_q.size() == 0) begin
				report($sformatf("unexpected char %h last %b", c, l));
			end else begin
				t = text_q.pop_front();
				if (c !== t.ch) begin
					report($sformatf("char_out %h, predicted %h", c, t.ch));
				end
				if (l !== t.lst) begin
					report($sformatf("last %b, predicted %b on char %h", l, t.lst, t.ch));
				end
			end
		endtask

		function int pending();
			return text_q.size();
		endfunction
	endclass

	logic        clk    = 1'b0;
	logic        arst_n = 1'b1;
	logic        start  = 1'b0;
	logic [63:0] value  = 64'd0;
	logic [1:0]  mode   = 2'd0;
	logic        busy;
	logic        strobe;
	logic [7:0]  char_out;
	logic        last;

	text_scoreboard sb;
	int             idle_pct = 16;

	integer_to_ascii_dec_hex dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.mode     (mode),
		.strobe   (strobe),
		.char_out (char_out),
		.last     (last)
	);

	always #6 clk = ~clk;

	// Output monitor: every strobe carries one character
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			sb.check_char(char_out, last);
		end
	end

	// Present one word, with a random gap first, and wait until it is taken
	task automatic send_word(input logic [63:0] v, input mode_t m);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		mode  <= m;
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		sb.note_word(v, m);
	endtask

	// Random value: full width, tiny, random length, near a decimal boundary or near the 32-bit maximum
	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		logic [63:0] p;
		int          w;
		r = {$urandom, $urandom};
		unique case ($urandom_range(4))
			0: return r;
			1: return {r[63:32], 32'($urandom_range(20))};
			2: begin
				w = $urandom_range(1, 64);
				return (w == 64) ? r : (r & ((64'd1 << w) - 64'd1));
			end
			3: begin
				p = 64'd1;
				repeat ($urandom_range(9)) p = p * 64'd10;
				return {r[63:32], 32'(p + 64'($urandom_range(2)) - 64'd1)};
			end
			default: return {r[63:32], 32'hFFFF_FFFF - 32'($urandom_range(3))};
		endcase
	endfunction

	initial begin
		mode_t m;
		sb = new();
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, extremes, ignored high bits, every digit and letter
		for (int i = 0; i < 4; i++) begin
			m = mode_t'(i);
			send_word(64'd0, m);
			send_word(64'hFFFF_FFFF_FFFF_FFFF, m);
			send_word(64'hFFFF_FFFF_0000_0000, m);
			send_word(64'h0123_4567_89AB_CDEF, m);
		end
		send_word(64'd9, MODE_DEC);
		send_word(64'd10, MODE_DEC);
		send_word(64'd1_000_000_000, MODE_DEC);
		send_word(64'd4_294_967_295, MODE_DEC);
		send_word(64'h0000_0000_FEDC_BA98, MODE_HEX_UP);
		send_word(64'h0000_0000_FEDC_BA98, MODE_HEX_LO);
		send_word(64'h8000_0000_0000_0000, MODE_PTR);
		send_word(64'd1, MODE_PTR);

		// Random words, with one long stretch of back-to-back starts
		for (int i = 0; i < 310; i++) begin
			idle_pct = (i >= 120 && i < 190) ? 0 : 16;
			m = mode_t'($urandom_range(3));
			send_word(pick_value(), m);
		end
		start <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
